### rtl/pfa_pkg.sv
// shared constants, codes and helper functions of the page frame allocator
package pfa_pkg;

  localparam int FRAME_COUNT = 65536;
  localparam int FRAME_W     = $clog2(FRAME_COUNT);
  localparam int LINK_W      = $clog2(FRAME_COUNT + 1);
  localparam int CFG_W       = 17;
  localparam int FIELD_W     = 16;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(FRAME_COUNT);

  localparam logic [CFG_W-1:0] RESV_START_RST = CFG_W'(160);
  localparam logic [CFG_W-1:0] RESV_END_RST   = CFG_W'(256);

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_INIT    = 2'd2;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_EMPTY      = 2'd1;
  localparam logic [1:0] STAT_NOT_IN_USE = 2'd2;

  localparam logic REG_RESV_START = 1'b0;
  localparam logic REG_RESV_END   = 1'b1;

  function automatic logic [LINK_W-1:0] clamp_frame(input logic [CFG_W-1:0] v);
    if (32'(v) > 32'(FRAME_COUNT)) begin
      return NIL_LINK;
    end else begin
      return LINK_W'(v);
    end
  endfunction

  function automatic logic [LINK_W-1:0] init_head(input logic [LINK_W-1:0] lo,
                                                  input logic [LINK_W-1:0] hi);
    if ((lo < hi) && (lo == '0)) begin
      return hi;
    end else begin
      return '0;
    end
  endfunction

endpackage

### rtl/pfa_ram.sv
// generic single write port, single read port ram with registered read
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/page_frame_free_list_allocator_top.sv
// page frame allocator top level: free list sequencer, link and in-use memories, apb registers
//
// An item is taken when start is high and busy is low. Allocate and release read the link
// or in-use memory in the cycle the item is taken and update it in the wait state; the result
// strobes on out_valid in the cycle after that, and a new item can be taken in that same cycle.
// Initialize sweeps every frame, writing both memories for one frame per cycle, and then
// strobes its result. After reset the block runs the same sweep with the reset register
// values (busy high, no result) before it takes an item. Results appear for one cycle on
// out_valid and cannot be held off. Register writes take effect at the next initialize.
module page_frame_free_list_allocator_top
  import pfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [FIELD_W-1:0] in_frame_number,
  output logic               out_valid,
  output logic [FIELD_W-1:0] out_granted_frame,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WAIT  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [1:0]         kind_r;
  logic               frame_ok_r;
  logic [FRAME_W-1:0] frame_r;
  logic [LINK_W-1:0]  head_r, head_nxt;
  logic [LINK_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [FRAME_W-1:0] cnt_r, cnt_nxt;
  logic               reply_r, reply_nxt;
  logic [CFG_W-1:0]   resv_start_r, resv_end_r;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_granted_r, out_granted_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  logic               accept;
  logic               cfg_wr;
  logic               link_we, use_we;
  logic [FRAME_W-1:0] link_waddr, use_waddr;
  logic [LINK_W-1:0]  link_wdata, link_rdata;
  logic               use_wdata, use_rdata;
  logic [LINK_W-1:0]  sweep_next;
  logic               sweep_resv;
  logic               resv_on;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RESV_END) ? 32'(resv_end_r) : 32'(resv_start_r);

  assign out_valid         = out_valid_r;
  assign out_granted_frame = out_granted_r;
  assign out_status        = out_status_r;

  pfa_ram #(.WIDTH(LINK_W), .DEPTH(FRAME_COUNT)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (head_r[FRAME_W-1:0]),
    .rdata (link_rdata)
  );

  pfa_ram #(.WIDTH(1), .DEPTH(FRAME_COUNT)) u_use_ram (
    .clk   (clk),
    .we    (use_we),
    .waddr (use_waddr),
    .wdata (use_wdata),
    .raddr (FRAME_W'(in_frame_number)),
    .rdata (use_rdata)
  );

  // sweep link value for the current frame
  always_comb begin
    resv_on    = (lo_r < hi_r);
    sweep_resv = resv_on && (LINK_W'(cnt_r) >= lo_r) && (LINK_W'(cnt_r) < hi_r);
    sweep_next = LINK_W'(cnt_r) + LINK_W'(1);
    if (resv_on && (sweep_next == lo_r)) begin
      sweep_next = hi_r;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    cnt_nxt         = cnt_r;
    reply_nxt       = reply_r;
    out_valid_nxt   = 1'b0;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    link_we         = 1'b0;
    link_waddr      = cnt_r;
    link_wdata      = sweep_resv ? NIL_LINK : sweep_next;
    use_we          = 1'b0;
    use_waddr       = cnt_r;
    use_wdata       = sweep_resv;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_INIT) begin
            lo_nxt    = clamp_frame(resv_start_r);
            hi_nxt    = clamp_frame(resv_end_r);
            head_nxt  = init_head(clamp_frame(resv_start_r), clamp_frame(resv_end_r));
            cnt_nxt   = '0;
            reply_nxt = 1'b1;
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        state_nxt       = S_IDLE;
        out_valid_nxt   = 1'b1;
        out_granted_nxt = '0;
        out_status_nxt  = STAT_OK;
        case (kind_r)
          KIND_ALLOC: begin
            if (head_r == NIL_LINK) begin
              out_status_nxt = STAT_EMPTY;
            end else begin
              use_we          = 1'b1;
              use_waddr       = head_r[FRAME_W-1:0];
              use_wdata       = 1'b1;
              out_granted_nxt = FIELD_W'(head_r);
              head_nxt        = link_rdata;
            end
          end
          KIND_RELEASE: begin
            if (!frame_ok_r || !use_rdata) begin
              out_status_nxt = STAT_NOT_IN_USE;
            end else begin
              use_we     = 1'b1;
              use_waddr  = frame_r;
              use_wdata  = 1'b0;
              link_we    = 1'b1;
              link_waddr = frame_r;
              link_wdata = head_r;
              head_nxt   = LINK_W'(frame_r);
            end
          end
          default: begin
          end
        endcase
      end
      S_SWEEP: begin
        link_we = 1'b1;
        use_we  = 1'b1;
        cnt_nxt = cnt_r + FRAME_W'(1);
        if (cnt_r == FRAME_W'(FRAME_COUNT - 1)) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = reply_r;
          out_granted_nxt = '0;
          out_status_nxt  = STAT_OK;
          reply_nxt       = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      lo_r         <= clamp_frame(RESV_START_RST);
      hi_r         <= clamp_frame(RESV_END_RST);
      head_r       <= init_head(clamp_frame(RESV_START_RST), clamp_frame(RESV_END_RST));
      cnt_r        <= '0;
      reply_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      resv_start_r <= RESV_START_RST;
      resv_end_r   <= RESV_END_RST;
    end else begin
      state_r     <= state_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_RESV_END) begin
          resv_end_r <= pwdata[CFG_W-1:0];
        end else begin
          resv_start_r <= pwdata[CFG_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
    if (accept) begin
      kind_r     <= in_kind;
      frame_r    <= FRAME_W'(in_frame_number);
      frame_ok_r <= (32'(in_frame_number) < 32'(FRAME_COUNT));
    end
  end

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_granted_r != '0)) |-> (out_status_r == STAT_OK))
    else $error("frame granted with error status");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("not busy after item taken");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= NIL_LINK)
    else $error("list head out of range");

  a_wait_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |=> (state_r == S_IDLE) && out_valid_r)
    else $error("wait state without result");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_WAIT) || ($past(state_r) == S_SWEEP))
    else $error("result strobe from idle");

endmodule

### tb/page_frame_free_list_allocator_top_test.sv
// testbench of the page frame allocator: directed table, random phases, shadow free list
module page_frame_free_list_allocator_top_test;
  import pfa_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef enum logic [1:0] {ROW_ITEM, ROW_WR_START, ROW_WR_END} row_op_t;

  typedef struct packed {
    row_op_t            op;
    logic [1:0]         kind;
    logic [CFG_W-1:0]   arg;
    bit                 typed;
    logic [FIELD_W-1:0] granted;
    logic [1:0]         status;
  } stim_row_t;

  typedef struct packed {
    logic [FIELD_W-1:0] granted;
    logic [1:0]         status;
  } grant_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = KIND_ALLOC;
  logic [FIELD_W-1:0] in_frame_number = '0;
  logic out_valid;
  logic [FIELD_W-1:0] out_granted_frame;
  logic [1:0] out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  page_frame_free_list_allocator_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_frame_number(in_frame_number),
    .out_valid(out_valid), .out_granted_frame(out_granted_frame), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // shadow of the allocator state
  logic [CFG_W-1:0]  resv_lo;
  logic [CFG_W-1:0]  resv_hi;
  logic [LINK_W-1:0] chain_head;
  logic [LINK_W-1:0] chain_next [FRAME_COUNT];
  bit                frame_taken [FRAME_COUNT];
  logic [FIELD_W-1:0] held_frames [$];

  grant_result_t pending_grants [$];
  grant_result_t oldest;
  stim_row_t     script [$];

  int idle_pct = 22;
  int inits_left = 2;
  int mismatches = 0;
  int cycles = 0;
  int items_sent = 0;
  int results_seen = 0;
  int n_granted = 0;
  int n_empty = 0;
  int n_released = 0;
  int n_not_in_use = 0;
  int n_rebuilds = 0;

  function automatic stim_row_t mk(row_op_t op, logic [1:0] kind, logic [CFG_W-1:0] arg,
                                   bit typed, logic [FIELD_W-1:0] granted, logic [1:0] status);
    stim_row_t r;
    r.op = op;
    r.kind = kind;
    r.arg = arg;
    r.typed = typed;
    r.granted = granted;
    r.status = status;
    return r;
  endfunction

  function automatic void rebuild_chain();
    int lo;
    int hi;
    int prev;
    lo = (int'(resv_lo) > FRAME_COUNT) ? FRAME_COUNT : int'(resv_lo);
    hi = (int'(resv_hi) > FRAME_COUNT) ? FRAME_COUNT : int'(resv_hi);
    prev = -1;
    chain_head = NIL_LINK;
    for (int f = 0; f < FRAME_COUNT; f++) begin
      chain_next[f] = NIL_LINK;
      if (lo < hi && f >= lo && f < hi) begin
        frame_taken[f] = 1'b1;
      end else begin
        frame_taken[f] = 1'b0;
        if (prev < 0) chain_head = LINK_W'(f);
        else chain_next[prev] = LINK_W'(f);
        prev = f;
      end
    end
    held_frames.delete();
  endfunction

  function automatic grant_result_t grant_step(logic [1:0] kind, logic [FIELD_W-1:0] frame);
    grant_result_t r;
    int f;
    r.granted = '0;
    r.status = STAT_OK;
    case (kind)
      KIND_ALLOC: begin
        if (chain_head >= NIL_LINK) begin
          r.status = STAT_EMPTY;
          n_empty++;
        end else begin
          f = int'(chain_head);
          r.granted = f[FIELD_W-1:0];
          frame_taken[f] = 1'b1;
          chain_head = chain_next[f];
          if (chain_head > NIL_LINK) chain_head = NIL_LINK;
          held_frames.push_back(f[FIELD_W-1:0]);
          n_granted++;
        end
      end
      KIND_RELEASE: begin
        if (!frame_taken[frame]) begin
          r.status = STAT_NOT_IN_USE;
          n_not_in_use++;
        end else begin
          frame_taken[frame] = 1'b0;
          chain_next[frame] = chain_head;
          chain_head = {1'b0, frame};
          for (int i = 0; i < held_frames.size(); i++) begin
            if (held_frames[i] == frame) begin
              held_frames.delete(i);
              break;
            end
          end
          n_released++;
        end
      end
      KIND_INIT: begin
        rebuild_chain();
        n_rebuilds++;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(logic [1:0] kind, logic [FIELD_W-1:0] frame, bit typed,
                           logic [FIELD_W-1:0] granted, logic [1:0] status);
    grant_result_t predicted;
    grant_result_t typed_in;
    in_kind <= kind;
    in_frame_number <= frame;
    forever begin
      start <= ($urandom_range(0, 99) >= idle_pct);
      @(posedge clk);
      if (start === 1'b1 && busy === 1'b0) break;
    end
    predicted = grant_step(kind, frame);
    typed_in.granted = granted;
    typed_in.status = status;
    pending_grants.push_back(typed ? typed_in : predicted);
    items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_grants.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic sel, logic [CFG_W-1:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {sel, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_RESV_START) resv_lo = val;
    else resv_hi = val;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi, int count,
                           int calm_from, int calm_to);
    logic [1:0] kind;
    logic [FIELD_W-1:0] frame;
    int r;
    settle();
    write_reg(REG_RESV_START, lo);
    write_reg(REG_RESV_END, hi);
    send_item(KIND_INIT, FIELD_W'($urandom), 1'b0, '0, STAT_OK);
    for (int i = 0; i < count; i++) begin
      idle_pct = (i >= calm_from && i < calm_to) ? 0 : 22;
      r = $urandom_range(0, 999);
      frame = FIELD_W'($urandom);
      if (r < 4 && inits_left > 0) begin
        kind = KIND_INIT;
        inits_left--;
      end else if (r < 30) begin
        kind = KIND_UNUSED;
      end else if (r < 530) begin
        kind = KIND_ALLOC;
      end else begin
        kind = KIND_RELEASE;
        if (held_frames.size() != 0 && $urandom_range(0, 99) < 60)
          frame = held_frames[$urandom_range(0, held_frames.size() - 1)];
      end
      send_item(kind, frame, 1'b0, '0, STAT_OK);
    end
    idle_pct = 22;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (pending_grants.size() == 0) begin
        report_mismatch("result with no item pending, granted", out_granted_frame, 0);
      end else begin
        oldest = pending_grants.pop_front();
        if (out_granted_frame !== oldest.granted)
          report_mismatch("granted_frame", out_granted_frame, oldest.granted);
        if (out_status !== oldest.status)
          report_mismatch("status", out_status, oldest.status);
      end
    end
  end

  initial begin
    resv_lo = RESV_START_RST;
    resv_hi = RESV_END_RST;
    rebuild_chain();

    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 1, 16'd0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 1, 16'd1, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_RELEASE, 0, 1, 16'd0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 1, 16'd0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_RELEASE, 17'hFFFF, 1, 16'd0, STAT_NOT_IN_USE));
    script.push_back(mk(ROW_ITEM, KIND_RELEASE, 5, 1, 16'd0, STAT_NOT_IN_USE));
    script.push_back(mk(ROW_ITEM, KIND_RELEASE, 160, 0, 0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 0, 0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_UNUSED, 17'hFFFF, 1, 16'd0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 0, 0, STAT_OK));
    script.push_back(mk(ROW_WR_START, KIND_ALLOC, 0, 0, 0, STAT_OK));
    script.push_back(mk(ROW_WR_END, KIND_ALLOC, 65532, 0, 0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_INIT, 0, 1, 16'd0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 1, 16'd65532, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 1, 16'd65533, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 1, 16'd65534, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 1, 16'd65535, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 1, 16'd0, STAT_EMPTY));
    script.push_back(mk(ROW_ITEM, KIND_RELEASE, 0, 0, 0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 0, 0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_RELEASE, 65535, 0, 0, STAT_OK));
    script.push_back(mk(ROW_WR_END, KIND_ALLOC, 65536, 0, 0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_INIT, 0, 1, 16'd0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 1, 16'd0, STAT_EMPTY));
    script.push_back(mk(ROW_ITEM, KIND_RELEASE, 17'hFFFF, 0, 0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 0, 0, STAT_OK));
    script.push_back(mk(ROW_ITEM, KIND_ALLOC, 0, 1, 16'd0, STAT_EMPTY));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].op == ROW_ITEM) begin
        send_item(script[i].kind, script[i].arg[FIELD_W-1:0], script[i].typed,
                  script[i].granted, script[i].status);
      end else begin
        settle();
        write_reg(script[i].op == ROW_WR_START ? REG_RESV_START : REG_RESV_END, script[i].arg);
      end
    end

    // small lists that drain, full list with clamped bounds, random bounds
    run_phase(CFG_W'($urandom_range(0, 40)), CFG_W'(65536 - $urandom_range(0, 40)), 400, 0, 0);
    run_phase(CFG_W'(65536), 17'h1FFFF, 400, 100, 300);
    run_phase(CFG_W'($urandom_range(1, 30)), CFG_W'($urandom_range(65500, 65536)), 400, 0, 0);
    run_phase(CFG_W'($urandom_range(0, 131071)), CFG_W'($urandom_range(0, 131071)), 430, 0, 0);

    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d items: %0d grants, %0d empty, %0d releases",
             items_sent, n_granted, n_empty, n_released);
    $display("%0d not in use, %0d rebuilds, %0d results checked, %0d mismatches",
             n_not_in_use, n_rebuilds, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
